/* hw/rtl/discrete_pid_biquad_top_macros.svh */
// Assertion macros for the PID biquad RTL.
`ifndef DISCRETE_PID_BIQUAD_TOP_MACROS_SVH
`define DISCRETE_PID_BIQUAD_TOP_MACROS_SVH

// Checked on every clock edge outside of reset.
`define DPB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define DPB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* hw/rtl/dpb_pkg.sv */
// Widths, reset coefficients and register indexes of the PID biquad.
package dpb_pkg;

    // Field widths and coefficient format.
    localparam int ERROR_WIDTH    = 16;
    localparam int DRIVE_WIDTH    = 24;
    localparam int COEF_FRAC_BITS = 24;
    localparam int COEF_WIDTH     = 32;
    localparam int NUM_COEFS      = 5;
    localparam int CFG_ADDR_W     = 3;

    // Stream word widths, padded to whole bytes.
    localparam int S_TDATA_W = ((ERROR_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DRIVE_WIDTH + 7) / 8) * 8;

    // Product widths and accumulator width (five terms need three guard bits).
    localparam int PE_W    = COEF_WIDTH + ERROR_WIDTH;
    localparam int PD_W    = COEF_WIDTH + DRIVE_WIDTH;
    localparam int PMAX_W  = (PE_W > PD_W) ? PE_W : PD_W;
    localparam int SUM_W   = PMAX_W + 3;
    localparam int RND_W   = SUM_W - COEF_FRAC_BITS;

    // Rounding offset and output bounds.
    localparam logic signed [SUM_W-1:0] ROUND_HALF =
        SUM_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
    localparam logic signed [RND_W-1:0] RND_MAX =
        RND_W'((64'sd1 <<< (DRIVE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [RND_W-1:0] RND_MIN =
        RND_W'(-(64'sd1 <<< (DRIVE_WIDTH - 1)));
    localparam logic signed [DRIVE_WIDTH-1:0] DRIVE_MAX = DRIVE_WIDTH'(RND_MAX);
    localparam logic signed [DRIVE_WIDTH-1:0] DRIVE_MIN = DRIVE_WIDTH'(RND_MIN);

    // Coefficient reset values, Q8.24.
    localparam logic signed [COEF_WIDTH-1:0] B0_RESET = 32'sd25334439;
    localparam logic signed [COEF_WIDTH-1:0] B1_RESET = -32'sd50415098;
    localparam logic signed [COEF_WIDTH-1:0] B2_RESET = 32'sd25080695;
    localparam logic signed [COEF_WIDTH-1:0] A1_RESET = -32'sd33387495;
    localparam logic signed [COEF_WIDTH-1:0] A2_RESET = 32'sd16610279;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } dpb_reg_t;

endpackage

/* hw/rtl/discrete_pid_biquad_top.sv */
// Top level of the Tustin PID controller realized as one biquad section.
//
//  Channel  Ports                        Word
//  -------  ---------------------------  --------------------------------------
//  input    s_tvalid s_tready s_tdata     error sample, 16-bit signed
//  result   m_tvalid m_tready m_tdata     drive, 24-bit signed; m_tuser = clip
//  config   cfg_we cfg_addr cfg_wdata     coefficient b0 b1 b2 a1 a2, Q8.24
//
// One word per cycle is sustained while m_tready stays high; a word passes the
// input register, then the result register. The limit is the feedback loop:
// five multiplies, their sum, rounding and clipping must settle before the next drive uses y1.
// Reset (aresetn low, synchronous) clears both stages, the histories and
// loads the default coefficients. A stalled result holds the output
// register; one more word may still enter the input register behind it.
module discrete_pid_biquad_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dpb_pkg::S_TDATA_W-1:0] s_tdata,   // [15:0] error_sample
    // Result stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dpb_pkg::M_TDATA_W-1:0] m_tdata,   // [23:0] drive
    output logic                          m_tuser,   // [0] saturated
    // Configuration writes.
    input  logic                          cfg_we,
    input  logic [dpb_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [dpb_pkg::COEF_WIDTH-1:0] cfg_wdata
);
    import dpb_pkg::*;

`include "discrete_pid_biquad_top_macros.svh"

    logic signed [COEF_WIDTH-1:0]  b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic                          in_valid_reg;
    logic signed [ERROR_WIDTH-1:0] in_error_reg;
    logic signed [ERROR_WIDTH-1:0] e1_reg, e2_reg;
    logic signed [DRIVE_WIDTH-1:0] y1_reg, y2_reg;
    logic                          out_valid_reg;
    logic signed [DRIVE_WIDTH-1:0] out_drive_reg;
    logic                          out_sat_reg;

    logic                          advance;
    logic signed [PE_W-1:0]        prod_b0, prod_b1, prod_b2;
    logic signed [PD_W-1:0]        prod_a1, prod_a2;
    logic signed [SUM_W-1:0]       acc;
    logic signed [RND_W-1:0]       rounded;
    logic signed [DRIVE_WIDTH-1:0] drive_next;
    logic                          sat_next;

    // Coefficient registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_reg <= B0_RESET;
            b1_reg <= B1_RESET;
            b2_reg <= B2_RESET;
            a1_reg <= A1_RESET;
            a2_reg <= A2_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_B0:  b0_reg <= cfg_wdata;
                REG_B1:  b1_reg <= cfg_wdata;
                REG_B2:  b2_reg <= cfg_wdata;
                REG_A1:  a1_reg <= cfg_wdata;
                REG_A2:  a2_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // The input register moves on whenever the result register is free or drains.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_error_reg <= s_tdata[ERROR_WIDTH-1:0];
        end
    end

    // Five products of the difference equation.
    assign prod_b0 = b0_reg * in_error_reg;
    assign prod_b1 = b1_reg * e1_reg;
    assign prod_b2 = b2_reg * e2_reg;
    assign prod_a1 = a1_reg * y1_reg;
    assign prod_a2 = a2_reg * y2_reg;

    // Exact sum plus one half, then floor: round to nearest, ties upward.
    assign acc = SUM_W'(prod_b0) + SUM_W'(prod_b1) + SUM_W'(prod_b2)
               - SUM_W'(prod_a1) - SUM_W'(prod_a2) + ROUND_HALF;
    assign rounded = acc[SUM_W-1:COEF_FRAC_BITS];

    // Clip to the drive range.
    always_comb begin
        priority if (rounded > RND_MAX) begin
            drive_next = DRIVE_MAX;
            sat_next   = 1'b1;
        end else if (rounded < RND_MIN) begin
            drive_next = DRIVE_MIN;
            sat_next   = 1'b1;
        end else begin
            drive_next = rounded[DRIVE_WIDTH-1:0];
            sat_next   = 1'b0;
        end
    end

    // Histories shift when a word leaves the input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_reg <= '0;
            e2_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
        end else if (in_valid_reg && advance) begin
            e1_reg <= in_error_reg;
            e2_reg <= e1_reg;
            y1_reg <= drive_next;
            y2_reg <= y1_reg;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid_reg && advance) begin
            out_drive_reg <= drive_next;
            out_sat_reg   <= sat_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'($unsigned(out_drive_reg));
    assign m_tuser  = out_sat_reg;

    // A clipped word always sits on one of the two bounds.
    `DPB_ASSERT(a_sat_at_bound, (m_tvalid && m_tuser) |-> (out_drive_reg == DRIVE_MAX || out_drive_reg == DRIVE_MIN), "saturated drive is not at a bound")
    // The drive on offer is the one fed back as y1.
    `DPB_ASSERT(a_feedback_matches, m_tvalid |-> (y1_reg == out_drive_reg), "y1 history differs from the pending drive")
    // Both stages full and the output stalled: no new word may enter.
    `DPB_ASSERT(a_full_blocks, (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready, "input accepted while both stages are full")
    // Reset empties both stages.
    `DPB_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> (!m_tvalid && !in_valid_reg), "stages not empty after reset")

endmodule

/* sim/discrete_pid_biquad_top_test.sv */
// Self-checking testbench for the Tustin PID biquad: streams error words and checks each drive word.
`timescale 1ns / 100ps

module discrete_pid_biquad_top_test;
    import dpb_pkg::*;

    // One expected drive word.
    typedef struct packed {
        logic signed [DRIVE_WIDTH-1:0] drive;
        logic                          saturated;
    } drive_word_t;

    // Tracks coefficients and histories, predicts drive words and checks them in order.
    class drive_scoreboard;
        logic signed [COEF_WIDTH-1:0]  coef [NUM_COEFS];
        logic signed [ERROR_WIDTH-1:0] err_hist [2];
        logic signed [DRIVE_WIDTH-1:0] drv_hist [2];
        drive_word_t                   pending [$];
        int                            mismatches;

        function new();
            coef[REG_B0] = B0_RESET;
            coef[REG_B1] = B1_RESET;
            coef[REG_B2] = B2_RESET;
            coef[REG_A1] = A1_RESET;
            coef[REG_A2] = A2_RESET;
            err_hist[0] = '0;
            err_hist[1] = '0;
            drv_hist[0] = '0;
            drv_hist[1] = '0;
            mismatches  = 0;
        endfunction

        // Writes to indexes past the last coefficient are dropped by the block.
        function void write_reg(int idx, logic [COEF_WIDTH-1:0] value);
            if (idx < NUM_COEFS) begin
                coef[idx] = value;
            end
        endfunction

        // Runs one filter step for an accepted error word and queues its drive word.
        function void note_error(logic signed [ERROR_WIDTH-1:0] e0);
            longint      hi = (longint'(1) <<< (DRIVE_WIDTH - 1)) - 1;
            longint      lo = -hi - 1;
            longint      acc;
            longint      rounded;
            drive_word_t want;
            acc = longint'(coef[REG_B0]) * longint'(e0)
                + longint'(coef[REG_B1]) * longint'(err_hist[0])
                + longint'(coef[REG_B2]) * longint'(err_hist[1])
                - longint'(coef[REG_A1]) * longint'(drv_hist[0])
                - longint'(coef[REG_A2]) * longint'(drv_hist[1]);
            // Round half up, then clip to the drive range.
            rounded = (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
            want.saturated = 1'b0;
            if (rounded > hi) begin
                rounded = hi;
                want.saturated = 1'b1;
            end else if (rounded < lo) begin
                rounded = lo;
                want.saturated = 1'b1;
            end
            want.drive = DRIVE_WIDTH'(rounded);
            // The clipped value is what feeds back.
            err_hist[1] = err_hist[0];
            err_hist[0] = e0;
            drv_hist[1] = drv_hist[0];
            drv_hist[0] = want.drive;
            pending.push_back(want);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t ns: %s", $time, msg);
            mismatches++;
        endtask

        // Compares one accepted drive word with the oldest prediction.
        task check_drive(logic [DRIVE_WIDTH-1:0] drive, logic saturated);
            drive_word_t want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("drive word %0d with none predicted", $signed(drive)));
            end else begin
                want = pending.pop_front();
                if (drive !== want.drive) begin
                    report_mismatch($sformatf("drive %0d, predicted %0d",
                                              $signed(drive), want.drive));
                end
                if (saturated !== want.saturated) begin
                    report_mismatch($sformatf("saturation flag %b, predicted %b",
                                              saturated, want.saturated));
                end
            end
        endtask
    endclass

    localparam int                    WATCHDOG_LIMIT = 3000;
    localparam logic [COEF_WIDTH-1:0] COEF_MAX       = 32'h7FFF_FFFF;
    localparam logic [COEF_WIDTH-1:0] COEF_MIN       = 32'h8000_0000;
    localparam logic [COEF_WIDTH-1:0] COEF_HALF      = 32'h0080_0000;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    m_tuser;
    logic                    cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]   cfg_addr  = '0;
    logic [COEF_WIDTH-1:0]   cfg_wdata = '0;

    drive_scoreboard         sb;
    int                      tx_idle_pct = 33;
    int                      rx_idle_pct = 60;
    int                      quiet_cycles = 0;
    logic [COEF_WIDTH-1:0]   coef_plan [NUM_COEFS];

    discrete_pid_biquad_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Result side: random back-pressure and in-order checking.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_drive(m_tdata[DRIVE_WIDTH-1:0], m_tuser);
        end
    end

    // Watchdog: too long without any word moving or register write ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Sends one error word, with random gaps ahead of it.
    task automatic send_error(input logic [ERROR_WIDTH-1:0] e);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(e);
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        sb.note_error(e);
    endtask

    // Stops the input and waits until every predicted drive word has arrived.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // Loads a coefficient set while idle, touching the unused indexes as well.
    task automatic load_coefs(input logic [COEF_WIDTH-1:0] b0, b1, b2, a1, a2);
        logic [COEF_WIDTH-1:0] word;
        wait_drained();
        coef_plan[REG_B0] = b0;
        coef_plan[REG_B1] = b1;
        coef_plan[REG_B2] = b2;
        coef_plan[REG_A1] = a1;
        coef_plan[REG_A2] = a2;
        for (int a = 0; a < (1 << CFG_ADDR_W); a++) begin
            word      = (a < NUM_COEFS) ? coef_plan[a] : $urandom;
            cfg_we    <= 1'b1;
            cfg_addr  <= CFG_ADDR_W'(a);
            cfg_wdata <= word;
            @(posedge aclk);
            sb.write_reg(a, word);
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly full-range errors, some small ones, now and then a bound.
    function automatic logic [ERROR_WIDTH-1:0] pick_error();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            1, 2, 3: return ERROR_WIDTH'(int'($urandom_range(0, 512)) - 256);
            default: return ERROR_WIDTH'($urandom);
        endcase
    endfunction

    // Random error words, with step runs that hold one value for a while.
    task automatic send_random(input int count);
        int                     sent;
        int                     run;
        logic [ERROR_WIDTH-1:0] e;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 4) == 0) begin
                e   = pick_error();
                run = $urandom_range(4, 16);
                repeat (run) send_error(e);
                sent += run;
            end else begin
                send_error(pick_error());
                sent++;
            end
        end
    endtask

    // Small random coefficient, a fraction of the full Q8.24 range.
    function automatic logic [COEF_WIDTH-1:0] small_coef();
        return $signed($urandom) >>> $urandom_range(4, 10);
    endfunction

    initial begin
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Field extremes and bit patterns with the reset coefficients.
        tx_idle_pct = 33;
        rx_idle_pct = 60;
        send_error(16'h0000);
        send_error(16'h7FFF);
        send_error(16'h8000);
        send_error(16'h0001);
        send_error(16'hFFFF);
        send_error(16'h5555);
        send_error(16'hAAAA);

        // Exact half results: ties round toward plus infinity.
        load_coefs(COEF_HALF, '0, '0, '0, '0);
        send_error(16'h0001);
        send_error(16'hFFFF);
        send_error(16'h0003);
        send_error(16'hFFFD);

        // Positive then negative saturation; clipped values feed back.
        load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN);
        repeat (3) send_error(16'h7FFF);
        repeat (3) send_error(16'h8000);
        load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX);
        repeat (2) send_error(16'h8000);
        repeat (2) send_error(16'h7FFF);

        // Reset coefficients restored, with a full drain halfway through.
        load_coefs(B0_RESET, B1_RESET, B2_RESET, A1_RESET, A2_RESET);
        send_random(250);
        wait_drained();
        send_random(250);

        // Receiver eager, sender sparse.
        tx_idle_pct = 60;
        rx_idle_pct = 33;
        load_coefs(small_coef(), small_coef(), small_coef(), small_coef(), small_coef());
        send_random(400);
        load_coefs($urandom, $urandom, $urandom, $urandom, $urandom);
        send_random(200);

        // No idling on either side.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        load_coefs(COEF_MIN, '0, '0, '0, '0);
        send_random(100);
        load_coefs(B0_RESET, B1_RESET, B2_RESET, A1_RESET, A2_RESET);
        send_random(600);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
